// File: design/ple_pkg.sv
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;

    // Widest cell index over the supported capacity range (up to 1024 cells)
    localparam int IDX_MAX_W = 10;

    typedef enum logic [2:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_AT    = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_BACK  = 3'd4,
        ACT_DEL_AT    = 3'd5,
        ACT_DISPLAY   = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_NOTFOUND = 2'd2,
        STS_FULL     = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        S_IDLE    = 1'b0,
        S_DISPLAY = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [IDX_MAX_W-1:0]   idx;
    } cell_cmd_t;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] value;
        logic [5:0]         position;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic               element_valid;
        logic               last;
    } rsp_t;

endpackage

// File: design/ple_cell.sv
// One storage cell of the list chain: holds a value and trades it with its neighbors.
`timescale 1ns / 1ps
module ple_cell #(
    parameter int INDEX = 0
) (
    input  logic                  clk,
    input  ple_pkg::cell_cmd_t    cmd,
    input  logic signed [31:0]    prev_value,
    input  logic signed [31:0]    next_value,
    input  logic signed [31:0]    head_value,
    input  logic signed [31:0]    ins_value,
    output logic signed [31:0]    value
);

    localparam logic [ple_pkg::IDX_MAX_W-1:0] MY_IDX = ple_pkg::IDX_MAX_W'(INDEX);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        case (cmd.op)
            ple_pkg::CELL_INSERT:
            begin
                if (MY_IDX == cmd.idx)
                begin
                    value_next = ins_value;
                end
                else if (MY_IDX > cmd.idx)
                begin
                    value_next = prev_value;
                end
            end
            ple_pkg::CELL_DELETE:
            begin
                if (MY_IDX >= cmd.idx)
                begin
                    value_next = next_value;
                end
            end
            ple_pkg::CELL_ROTATE:
            begin
                // the back cell of the list wraps the head around
                if (MY_IDX == cmd.idx)
                begin
                    value_next = head_value;
                end
                else if (MY_IDX < cmd.idx)
                begin
                    value_next = next_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: design/positional_list_engine.sv
// Top level: ordered list held in a chain of cells, with edit and display control.
// An edit acts on accept; its status sits in the result register next cycle.
// Throughput: one edit per cycle while results are taken; all cells shift in parallel.
// An empty list displays as one status result; n elements hold the input from acceptance
// to the last, one per cycle while results are taken, rotating the chain via the head cell.
// Reset clears length, control state and result valid; cell contents stay undefined.
`timescale 1ns / 1ps
module positional_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  ple_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output ple_pkg::rsp_t   rsp
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CW    = ((LEN_W > 6) ? LEN_W : 6) + 1;
    localparam int IW    = ple_pkg::IDX_MAX_W;

    ple_pkg::state_t    state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    ple_pkg::rsp_t      rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    ple_pkg::cell_cmd_t cmd;
    logic signed [31:0] cell_val [CAPACITY];

    logic               slot_free;
    logic               accept;
    logic               full;
    logic               empty;
    logic [CW-1:0]      pos_ext;
    logic [CW-1:0]      len_ext;
    logic               ins_pos_ok;
    logic               del_pos_ok;
    logic [IW-1:0]      pos_idx;
    logic [IW-1:0]      len_idx;
    logic [IW-1:0]      lenm1_idx;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            ple_cell #(
                .INDEX(g)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .prev_value ((g == 0) ? req.value : cell_val[(g == 0) ? 0 : g - 1]),
                .next_value ((g == CAPACITY - 1) ? cell_val[g]
                                                 : cell_val[(g == CAPACITY - 1) ? g : g + 1]),
                .head_value (cell_val[0]),
                .ins_value  (req.value),
                .value      (cell_val[g])
            );
        end
    endgenerate

    assign slot_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready  = (state_reg == ple_pkg::S_IDLE) && slot_free;
    assign accept     = req_valid && req_ready;
    assign full       = (len_reg == LEN_W'(CAPACITY));
    assign empty      = (len_reg == '0);
    assign pos_ext    = CW'(req.position);
    assign len_ext    = CW'(len_reg);
    assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= len_ext + CW'(1));
    assign del_pos_ok = (pos_ext != '0) && (pos_ext <= len_ext);
    assign pos_idx    = IW'(pos_ext - CW'(1));
    assign len_idx    = IW'(len_reg);
    assign lenm1_idx  = IW'(len_reg - LEN_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd.op         = ple_pkg::CELL_HOLD;
        cmd.idx        = '0;

        case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.status        = ple_pkg::STS_OK;
                    rsp_next.element       = '0;
                    rsp_next.element_valid = 1'b0;
                    rsp_next.last          = 1'b1;
                    rsp_valid_next         = 1'b1;
                    case (req.action)
                        ple_pkg::ACT_INS_FRONT,
                        ple_pkg::ACT_INS_BACK,
                        ple_pkg::ACT_INS_AT:
                        begin
                            if (full)
                            begin
                                rsp_next.status = ple_pkg::STS_FULL;
                            end
                            else if (req.action == ple_pkg::ACT_INS_AT && !ins_pos_ok)
                            begin
                                rsp_next.status = ple_pkg::STS_NOTFOUND;
                            end
                            else
                            begin
                                cmd.op   = ple_pkg::CELL_INSERT;
                                len_next = len_reg + LEN_W'(1);
                                if (req.action == ple_pkg::ACT_INS_FRONT)
                                begin
                                    cmd.idx = '0;
                                end
                                else if (req.action == ple_pkg::ACT_INS_BACK)
                                begin
                                    cmd.idx = len_idx;
                                end
                                else
                                begin
                                    cmd.idx = pos_idx;
                                end
                            end
                        end
                        ple_pkg::ACT_DEL_FRONT,
                        ple_pkg::ACT_DEL_BACK,
                        ple_pkg::ACT_DEL_AT:
                        begin
                            if (empty)
                            begin
                                rsp_next.status = ple_pkg::STS_EMPTY;
                            end
                            else if (req.action == ple_pkg::ACT_DEL_AT && !del_pos_ok)
                            begin
                                rsp_next.status = ple_pkg::STS_NOTFOUND;
                            end
                            else
                            begin
                                cmd.op   = ple_pkg::CELL_DELETE;
                                len_next = len_reg - LEN_W'(1);
                                if (req.action == ple_pkg::ACT_DEL_FRONT)
                                begin
                                    cmd.idx = '0;
                                end
                                else if (req.action == ple_pkg::ACT_DEL_BACK)
                                begin
                                    cmd.idx = lenm1_idx;
                                end
                                else
                                begin
                                    cmd.idx = pos_idx;
                                end
                            end
                        end
                        ple_pkg::ACT_DISPLAY:
                        begin
                            if (empty)
                            begin
                                rsp_next.status = ple_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                // elements go out from the display state
                                rsp_valid_next = rsp_valid_reg && !rsp_ready;
                                rsp_next       = rsp_reg;
                                cnt_next       = '0;
                                state_next     = ple_pkg::S_DISPLAY;
                            end
                        end
                        default:
                        begin
                            // unused code: drop without a result
                            rsp_valid_next = rsp_valid_reg && !rsp_ready;
                            rsp_next       = rsp_reg;
                        end
                    endcase
                end
            end
            ple_pkg::S_DISPLAY:
            begin
                if (slot_free)
                begin
                    // emit the head and rotate it to the back of the list
                    rsp_next.status        = ple_pkg::STS_OK;
                    rsp_next.element       = cell_val[0];
                    rsp_next.element_valid = 1'b1;
                    rsp_next.last          = (cnt_reg == len_reg - LEN_W'(1));
                    rsp_valid_next         = 1'b1;
                    cmd.op                 = ple_pkg::CELL_ROTATE;
                    cmd.idx                = lenm1_idx;
                    cnt_next               = cnt_reg + LEN_W'(1);
                    if (cnt_reg == len_reg - LEN_W'(1))
                    begin
                        state_next = ple_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ple_pkg::S_IDLE;
            len_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    a_display_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ple_pkg::S_DISPLAY) |-> (cnt_reg < len_reg))
        else $error("display count outside list");

    a_elem_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.element_valid) |-> (rsp_reg.status == ple_pkg::STS_OK))
        else $error("element result with bad status");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && (req.action == ple_pkg::ACT_INS_FRONT ||
                            req.action == ple_pkg::ACT_INS_BACK ||
                            req.action == ple_pkg::ACT_INS_AT))
        |=> (len_reg == $past(len_reg)))
        else $error("insert into full list changed length");

endmodule
